FILE: hw/rtl/iml_pkg.sv
// Shared types and constants for the Ising lattice engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package iml_pkg;

    // Lattice geometry
    localparam int MAX_SIDE  = 64;
    localparam int IDX_W     = 6;
    localparam int SIDE_W    = 7;
    localparam int PROB_BITS = 16;

    // Totals and their clamp limits
    localparam int E_W   = 15;
    localparam int M_W   = 14;
    localparam int E_LIM = 2 * MAX_SIDE * MAX_SIDE;
    localparam int M_LIM = MAX_SIDE * MAX_SIDE;

    localparam int ACC_W = 63;
    localparam int CNT_W = 32;

    // Energy changes of a single flip that need the random test
    localparam int DE_PLUS4 = 4;
    localparam int DE_PLUS8 = 8;
    localparam int DE_BASE  = -8;

    // Reset values
    localparam logic [SIDE_W-1:0]    SIDE_RST   = 7'd16;
    localparam logic [PROB_BITS-1:0] TH4_RST    = 16'd1200;
    localparam logic [PROB_BITS-1:0] TH8_RST    = 16'd22;
    localparam logic [CNT_W-1:0]     WARMUP_RST = 32'd0;
    localparam logic signed [E_W-1:0] ENERGY_RST = -15'sd512;
    localparam logic signed [M_W-1:0] MAGNET_RST = 14'sd256;

    // Item kinds
    localparam logic [1:0] KIND_SET   = 2'd0;
    localparam logic [1:0] KIND_FLIP  = 2'd1;
    localparam logic [1:0] KIND_CYCLE = 2'd2;

    // Register indexes (byte address 4*index)
    localparam logic [1:0] REG_SIDE   = 2'd0;
    localparam logic [1:0] REG_TH4    = 2'd1;
    localparam logic [1:0] REG_TH8    = 2'd2;
    localparam logic [1:0] REG_WARMUP = 2'd3;

    // Beat widths
    localparam int IN_W  = 32;
    localparam int OUT_W = 352;

    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    addr;
        logic [MAX_SIDE-1:0] data;
    } lat_wr_t;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
    } stats_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/iml_lattice_mem.sv
// Spin lattice store: one row of spins per entry, two registered read ports.
// Depends on iml_pkg. Rows never written read back as all spins up.
`default_nettype none

module iml_lattice_mem
    import iml_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                rd_a_en,
    input  wire logic [IDX_W-1:0]    rd_a_addr,
    input  wire logic                rd_b_en,
    input  wire logic [IDX_W-1:0]    rd_b_addr,
    input  wire lat_wr_t             wr,
    output logic      [MAX_SIDE-1:0] rd_a_data,
    output logic      [MAX_SIDE-1:0] rd_b_data
);

    logic [MAX_SIDE-1:0] lattice_mem [MAX_SIDE];
    logic [MAX_SIDE-1:0] row_valid_reg;
    logic [MAX_SIDE-1:0] a_data_reg;
    logic [MAX_SIDE-1:0] b_data_reg;
    logic                a_valid_reg;
    logic                b_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            lattice_mem[wr.addr] <= wr.data;
        end
        if (rd_a_en)
        begin
            a_data_reg <= lattice_mem[rd_a_addr];
        end
        if (rd_b_en)
        begin
            b_data_reg <= lattice_mem[rd_b_addr];
        end
    end

    // per-row valid bits stand in for the all-up reset image
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                row_valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_a_en)
            begin
                a_valid_reg <= row_valid_reg[rd_a_addr];
            end
            if (rd_b_en)
            begin
                b_valid_reg <= row_valid_reg[rd_b_addr];
            end
        end
    end

    assign rd_a_data = a_valid_reg ? a_data_reg : '1;
    assign rd_b_data = b_valid_reg ? b_data_reg : '1;

endmodule

`default_nettype wire

FILE: hw/rtl/iml_stats.sv
// Measurement accumulators: E, E^2, M^2, |M| with saturation.
// Depends on iml_pkg. Square stage registered ahead of the wide adds.
`default_nettype none

module iml_stats
    import iml_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire stats_ctrl_t             ctrl,
    input  wire logic signed [E_W-1:0]   energy,
    input  wire logic signed [M_W-1:0]   magnet,
    output logic             [ACC_W-1:0] sum_energy,
    output logic             [ACC_W-1:0] sum_energy_sq,
    output logic             [ACC_W-1:0] sum_mag_sq,
    output logic             [ACC_W-1:0] sum_abs_mag
);

    logic signed [2*E_W-1:0] e_prod;
    logic signed [2*M_W-1:0] m_prod;
    logic signed [M_W-1:0]   m_neg;
    logic [26:0]             e_sq_reg;
    logic [24:0]             m_sq_reg;
    logic [12:0]             m_abs_reg;
    logic signed [E_W-1:0]   e_hold_reg;

    logic [ACC_W-1:0] acc_e_reg,  acc_e_next;
    logic [ACC_W-1:0] acc_esq_reg, acc_esq_next;
    logic [ACC_W-1:0] acc_msq_reg, acc_msq_next;
    logic [ACC_W-1:0] acc_mabs_reg, acc_mabs_next;

    logic signed [ACC_W:0] e_sum;
    logic [ACC_W:0]        esq_sum;
    logic [ACC_W:0]        msq_sum;
    logic [ACC_W:0]        mabs_sum;

    assign e_prod = energy * energy;
    assign m_prod = magnet * magnet;
    assign m_neg  = -magnet;

    // square stage
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            e_sq_reg   <= e_prod[26:0];
            m_sq_reg   <= m_prod[24:0];
            m_abs_reg  <= magnet[M_W-1] ? m_neg[12:0] : magnet[12:0];
            e_hold_reg <= energy;
        end
    end

    always_comb
    begin
        e_sum    = $signed({acc_e_reg[ACC_W-1], acc_e_reg}) + 64'(e_hold_reg);
        esq_sum  = {1'b0, acc_esq_reg}  + 64'(e_sq_reg);
        msq_sum  = {1'b0, acc_msq_reg}  + 64'(m_sq_reg);
        mabs_sum = {1'b0, acc_mabs_reg} + 64'(m_abs_reg);

        // signed: out of range when the top two bits differ
        if (e_sum[ACC_W] == e_sum[ACC_W-1])
            acc_e_next = e_sum[ACC_W-1:0];
        else if (e_sum[ACC_W])
            acc_e_next = {1'b1, {(ACC_W-1){1'b0}}};
        else
            acc_e_next = {1'b0, {(ACC_W-1){1'b1}}};

        acc_esq_next  = esq_sum[ACC_W]  ? '1 : esq_sum[ACC_W-1:0];
        acc_msq_next  = msq_sum[ACC_W]  ? '1 : msq_sum[ACC_W-1:0];
        acc_mabs_next = mabs_sum[ACC_W] ? '1 : mabs_sum[ACC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_e_reg    <= '0;
            acc_esq_reg  <= '0;
            acc_msq_reg  <= '0;
            acc_mabs_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_e_reg    <= acc_e_next;
            acc_esq_reg  <= acc_esq_next;
            acc_msq_reg  <= acc_msq_next;
            acc_mabs_reg <= acc_mabs_next;
        end
    end

    assign sum_energy    = acc_e_reg;
    assign sum_energy_sq = acc_esq_reg;
    assign sum_mag_sq    = acc_msq_reg;
    assign sum_abs_mag   = acc_mabs_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/ising_metropolis_lattice_engine_unit.sv
// Ising lattice engine top: 2D periodic spin lattice with Metropolis flips.
// Depends on iml_pkg, iml_lattice_mem, iml_stats.
// Sequence: a set/flip item passes S_RD0 (read the site row and the row above),
//   S_RD1 (read the row below), S_CALC (decide and write back) and S_OUT (load
//   the result); an end-of-cycle item S_MUL, S_ACC, S_OUT; others only S_OUT.
// A new item is taken only in S_IDLE, after the previous result is loaded.
// Reset: async, active low; registers to defaults, lattice reads all up at once.
`default_nettype none

module ising_metropolis_lattice_engine_unit
    import iml_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // input stream
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // [5:0] row, [11:6] col, [12] spin_up, [28:13] random_fraction, rest zero
    input  wire logic [IN_W-1:0]  s_tdata,
    // [1:0] kind
    input  wire logic [1:0]       s_tuser,
    // result stream
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // [0] flipped, [15:1] energy, [29:16] magnetization, [92:30] sum_energy,
    // [155:93] sum_energy_sq, [218:156] sum_mag_sq, [281:219] sum_abs_mag,
    // [313:282] measured_cycles, [345:314] accepted_count, rest zero
    output logic [OUT_W-1:0]      m_tdata,
    // configuration port
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [3:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD0  = 3'd1;
    localparam logic [2:0] S_RD1  = 3'd2;
    localparam logic [2:0] S_CALC = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_ACC  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [SIDE_W-1:0]    side_reg;
    logic [PROB_BITS-1:0] th4_reg;
    logic [PROB_BITS-1:0] th8_reg;
    logic [CNT_W-1:0]     warmup_reg;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg   <= SIDE_RST;
            th4_reg    <= TH4_RST;
            th8_reg    <= TH8_RST;
            warmup_reg <= WARMUP_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_SIDE:   side_reg   <= pwdata[SIDE_W-1:0];
                REG_TH4:    th4_reg    <= pwdata[PROB_BITS-1:0];
                REG_TH8:    th8_reg    <= pwdata[PROB_BITS-1:0];
                REG_WARMUP: warmup_reg <= pwdata[CNT_W-1:0];
                default:    side_reg   <= side_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SIDE:   prdata = 32'(side_reg);
            REG_TH4:    prdata = 32'(th4_reg);
            REG_TH8:    prdata = 32'(th8_reg);
            REG_WARMUP: prdata = warmup_reg;
            default:    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Input beat decode and site geometry
    // ---------------------------------------------------------------
    logic [1:0]           in_kind;
    logic [IDX_W-1:0]     in_row;
    logic [IDX_W-1:0]     in_col;
    logic                 in_spin;
    logic [PROB_BITS-1:0] in_rf;
    logic [SIDE_W-1:0]    eff_side;
    logic                 in_range;
    logic                 in_accept;

    assign in_kind = s_tuser;
    assign in_row  = s_tdata[5:0];
    assign in_col  = s_tdata[11:6];
    assign in_spin = s_tdata[12];
    assign in_rf   = s_tdata[28:13];

    // side clamped into [2, MAX_SIDE]
    assign eff_side = (side_reg < 7'd2) ? 7'd2 :
                      ((side_reg > 7'(MAX_SIDE)) ? 7'(MAX_SIDE) : side_reg);
    assign in_range = ({1'b0, in_row} < eff_side) && ({1'b0, in_col} < eff_side);

    function automatic logic [IDX_W-1:0] wrap_prev(input logic [IDX_W-1:0] i,
                                                   input logic [SIDE_W-1:0] l);
        logic [SIDE_W-1:0] last;
        last = l - 7'd1;
        return (i == '0) ? last[IDX_W-1:0] : i - 6'd1;
    endfunction

    function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] i,
                                                   input logic [SIDE_W-1:0] l);
        return (({1'b0, i} + 7'd1) >= l) ? '0 : i + 6'd1;
    endfunction

    // ---------------------------------------------------------------
    // Sequencer and held item
    // ---------------------------------------------------------------
    logic [2:0]           state_reg, state_next;
    logic [1:0]           kind_reg;
    logic [IDX_W-1:0]     row_reg;
    logic [IDX_W-1:0]     col_reg;
    logic                 spin_reg;
    logic [PROB_BITS-1:0] rf_reg;
    logic [IDX_W-1:0]     up_row_reg;
    logic [IDX_W-1:0]     dn_row_reg;
    logic [IDX_W-1:0]     lf_col_reg;
    logic [IDX_W-1:0]     rt_col_reg;
    logic                 up_bit_reg;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // lattice memory hookup
    logic                rd_a_en;
    logic                rd_b_en;
    logic [IDX_W-1:0]    rd_b_addr;
    logic [MAX_SIDE-1:0] rd_a_data;
    logic [MAX_SIDE-1:0] rd_b_data;
    lat_wr_t             lat_wr;

    assign rd_a_en   = (state_reg == S_RD0);
    assign rd_b_en   = (state_reg == S_RD0) || (state_reg == S_RD1);
    assign rd_b_addr = (state_reg == S_RD0) ? up_row_reg : dn_row_reg;

    iml_lattice_mem u_lattice (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_a_en   (rd_a_en),
        .rd_a_addr (row_reg),
        .rd_b_en   (rd_b_en),
        .rd_b_addr (rd_b_addr),
        .wr        (lat_wr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    // ---------------------------------------------------------------
    // Flip decision (S_CALC: site row on port A, row below on port B)
    // ---------------------------------------------------------------
    logic                 self_bit;
    logic [2:0]           up_count;
    logic signed [5:0]    de_up;
    logic signed [5:0]    de;
    logic                 flip_ok;
    logic                 do_flip;
    logic                 measuring;

    assign self_bit = rd_a_data[col_reg];
    assign up_count = 3'(up_bit_reg) + 3'(rd_b_data[col_reg])
                    + 3'(rd_a_data[lf_col_reg]) + 3'(rd_a_data[rt_col_reg]);

    // dE = 2*s*(sum of neighbours); neighbour sum is 2*ups - 4
    assign de_up = $signed({1'b0, up_count, 2'b00}) + 6'(DE_BASE);
    assign de    = self_bit ? de_up : -de_up;

    assign flip_ok = (de <= 6'sd0)
                  || ((de == 6'(DE_PLUS4)) && (rf_reg <= th4_reg))
                  || ((de == 6'(DE_PLUS8)) && (rf_reg <= th8_reg));

    assign do_flip = (state_reg == S_CALC)
                  && (((kind_reg == KIND_SET) && (self_bit != spin_reg))
                   || ((kind_reg == KIND_FLIP) && flip_ok));

    assign lat_wr.en   = do_flip;
    assign lat_wr.addr = row_reg;
    assign lat_wr.data = rd_a_data ^ (64'd1 << col_reg);

    // ---------------------------------------------------------------
    // Running totals and counters
    // ---------------------------------------------------------------
    logic signed [E_W-1:0] energy_reg, energy_next;
    logic signed [M_W-1:0] magnet_reg, magnet_next;
    logic [CNT_W-1:0]      cycle_count_reg;
    logic [CNT_W-1:0]      accept_count_reg;
    logic signed [E_W:0]   e_sum;
    logic signed [M_W:0]   m_sum;
    logic                  flipped_reg;

    assign measuring = (cycle_count_reg >= warmup_reg);

    always_comb
    begin
        e_sum = $signed({energy_reg[E_W-1], energy_reg}) + 16'(de);
        m_sum = $signed({magnet_reg[M_W-1], magnet_reg}) + (self_bit ? -15'sd2 : 15'sd2);

        if (e_sum > E_LIM)
            energy_next = 15'(E_LIM);
        else if (e_sum < -E_LIM)
            energy_next = 15'(-E_LIM);
        else
            energy_next = e_sum[E_W-1:0];

        if (m_sum > M_LIM)
            magnet_next = 14'(M_LIM);
        else if (m_sum < -M_LIM)
            magnet_next = 14'(-M_LIM);
        else
            magnet_next = m_sum[M_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg       <= ENERGY_RST;
            magnet_reg       <= MAGNET_RST;
            cycle_count_reg  <= '0;
            accept_count_reg <= '0;
            flipped_reg      <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                flipped_reg <= 1'b0;
            end
            if (do_flip)
            begin
                energy_reg <= energy_next;
                magnet_reg <= magnet_next;
            end
            if (do_flip && (kind_reg == KIND_FLIP))
            begin
                flipped_reg <= 1'b1;
                if (measuring && (accept_count_reg != '1))
                begin
                    accept_count_reg <= accept_count_reg + 32'd1;
                end
            end
            if ((state_reg == S_ACC) && (cycle_count_reg != '1))
            begin
                cycle_count_reg <= cycle_count_reg + 32'd1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Measurement accumulators
    // ---------------------------------------------------------------
    stats_ctrl_t      stats_ctrl;
    logic [ACC_W-1:0] sum_energy;
    logic [ACC_W-1:0] sum_energy_sq;
    logic [ACC_W-1:0] sum_mag_sq;
    logic [ACC_W-1:0] sum_abs_mag;

    assign stats_ctrl.mul_en = (state_reg == S_MUL);
    assign stats_ctrl.acc_en = (state_reg == S_ACC) && measuring;

    iml_stats u_stats (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (stats_ctrl),
        .energy        (energy_reg),
        .magnet        (magnet_reg),
        .sum_energy    (sum_energy),
        .sum_energy_sq (sum_energy_sq),
        .sum_mag_sq    (sum_mag_sq),
        .sum_abs_mag   (sum_abs_mag)
    );

    // ---------------------------------------------------------------
    // State machine
    // ---------------------------------------------------------------
    logic out_load;
    logic m_valid_reg;

    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (((in_kind == KIND_SET) || (in_kind == KIND_FLIP)) && in_range)
                        state_next = S_RD0;
                    else if (in_kind == KIND_CYCLE)
                        state_next = S_MUL;
                    else
                        state_next = S_OUT;
                end
            end
            S_RD0:   state_next = S_RD1;
            S_RD1:   state_next = S_CALC;
            S_CALC:  state_next = S_OUT;
            S_MUL:   state_next = S_ACC;
            S_ACC:   state_next = S_OUT;
            S_OUT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // item capture, neighbor coordinates wrapped on the current side
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg   <= in_kind;
            row_reg    <= in_row;
            col_reg    <= in_col;
            spin_reg   <= in_spin;
            rf_reg     <= in_rf;
            up_row_reg <= wrap_prev(in_row, eff_side);
            dn_row_reg <= wrap_next(in_row, eff_side);
            lf_col_reg <= wrap_prev(in_col, eff_side);
            rt_col_reg <= wrap_next(in_col, eff_side);
        end
        if (state_reg == S_RD1)
        begin
            up_bit_reg <= rd_b_data[col_reg];
        end
    end

    // ---------------------------------------------------------------
    // Result register: holds one finished beat while the next item runs
    // ---------------------------------------------------------------
    logic [OUT_W-1:0] m_data_reg;
    logic [CNT_W-1:0] measured;

    assign measured = (cycle_count_reg > warmup_reg) ? (cycle_count_reg - warmup_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (out_load)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= {6'd0, accept_count_reg, measured, sum_abs_mag, sum_mag_sq,
                           sum_energy_sq, sum_energy, magnet_reg, energy_reg, flipped_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // lattice writes come only from a set or flip decision
    a_wr_from_calc: assert property (@(posedge clk) disable iff (!rst_n)
        lat_wr.en |-> (state_reg == S_CALC &&
                       (kind_reg == KIND_SET || kind_reg == KIND_FLIP)))
        else $error("lattice write outside decision step");

    // totals stay within their clamp limits
    a_totals_range: assert property (@(posedge clk) disable iff (!rst_n)
        (energy_reg <= E_LIM && energy_reg >= -E_LIM &&
         magnet_reg <= M_LIM && magnet_reg >= -M_LIM))
        else $error("running totals out of range");

    // accepted-flip count moves only after an accepted flip attempt
    a_accept_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (accept_count_reg != $past(accept_count_reg)) |->
            $past(do_flip && kind_reg == KIND_FLIP))
        else $error("accept count changed without accepted flip");

    // sweep counter never goes backward
    a_cycle_mono: assert property (@(posedge clk) disable iff (!rst_n)
        cycle_count_reg >= $past(cycle_count_reg))
        else $error("cycle count decreased");

endmodule

`default_nettype wire

FILE: bench/ising_metropolis_lattice_engine_unit_tb.sv
// Self-checking bench for the Ising lattice engine: random streams and APB register phases,
// with every result beat checked against a lattice predictor kept inside the bench.
// Depends on iml_pkg and ising_metropolis_lattice_engine_unit; reads no files.
`default_nettype none

module tb;
    import iml_pkg::*;

    localparam int CLK_PERIOD       = 12;
    localparam int RESET_CYCLES     = 12;
    localparam int IDLE_PCT         = 15;
    localparam int HOLD_CYCLES      = 400;
    localparam int SETTLE_CYCLES    = 8;      // settle time after a drain, before register writes
    localparam int RUN_LIMIT_CYCLES = 500_000;

    // kind 3 has no meaning; the block just reports its state
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam longint      ESUM_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam longint      ESUM_MIN = -ESUM_MAX - 1;
    localparam logic [63:0] USUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] CNT_MAX  = 64'h0000_0000_FFFF_FFFF;

    // one input beat; the low 29 bits line up with s_tdata
    typedef struct packed {
        logic [1:0]           kind;
        logic [PROB_BITS-1:0] frac;
        logic                 up;
        logic [IDX_W-1:0]     col;
        logic [IDX_W-1:0]     row;
    } beat_t;

    // one result beat, declared MSB first so it maps straight onto m_tdata[345:0]
    typedef struct packed {
        logic [CNT_W-1:0] accepted_count;
        logic [CNT_W-1:0] measured_cycles;
        logic [ACC_W-1:0] sum_abs_mag;
        logic [ACC_W-1:0] sum_mag_sq;
        logic [ACC_W-1:0] sum_energy_sq;
        logic [ACC_W-1:0] sum_energy;
        logic [M_W-1:0]   magnetization;
        logic [E_W-1:0]   energy;
        logic             flipped;
    } result_t;

    // ------------------------------------------------------------------
    // DUT ports; every input the bench drives is known from time zero
    // ------------------------------------------------------------------
    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic [1:0]       s_tuser  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             psel     = 1'b0;
    logic             penable  = 1'b0;
    logic             pwrite   = 1'b0;
    logic [3:0]       paddr    = '0;
    logic [31:0]      pwdata   = '0;
    logic [31:0]      prdata;
    logic             pready;

    ising_metropolis_lattice_engine_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------
    // Lattice predictor state: spins, totals, accumulators and a shadow
    // of the four registers.
    // ------------------------------------------------------------------
    bit                   lattice_up [0:MAX_SIDE*MAX_SIDE-1];
    int                   energy_now    = ENERGY_RST;
    int                   magnet_now    = MAGNET_RST;
    longint               energy_sum    = 0;
    logic [63:0]          energy_sq_sum = '0;
    logic [63:0]          mag_sq_sum    = '0;
    logic [63:0]          abs_mag_sum   = '0;
    logic [63:0]          sweeps_done   = '0;
    logic [63:0]          flips_counted = '0;
    logic [SIDE_W-1:0]    side_cfg      = SIDE_RST;
    logic [PROB_BITS-1:0] th4_cfg       = TH4_RST;
    logic [PROB_BITS-1:0] th8_cfg       = TH8_RST;
    logic [CNT_W-1:0]     warmup_cfg    = WARMUP_RST;

    // Bench bookkeeping
    beat_t   beats_to_send [$];      // stimulus not yet offered
    result_t pending_results [$];    // predictions waiting for their result beat
    beat_t   next_beat;
    beat_t   taken_beat;
    result_t seen_res;
    int      beats_taken  = 0;       // input handshakes, counted at posedge
    int      beats_seen   = 0;       // driver's copy, to spot a completed beat
    int      mismatches   = 0;
    int      holds_asked  = 0;
    int      holds_served = 0;
    int      hold_left    = 0;
    bit      no_idle      = 1'b0;

    // Side below 2 behaves as 2, above MAX_SIDE as MAX_SIDE
    function automatic int lattice_side();
        if (side_cfg < 2)
            return 2;
        if (side_cfg > MAX_SIDE)
            return MAX_SIDE;
        return int'(side_cfg);
    endfunction

    function automatic int spin_of(int r, int c);
        return lattice_up[r * MAX_SIDE + c] ? 1 : -1;
    endfunction

    // Periodic wrap; on a side of 2 both neighbours along a line are the same
    // site and get counted twice, which is what the block does too.
    function automatic int neighbour_total(int r, int c, int n);
        int north, south, west, east;
        north = (r == 0) ? n - 1 : r - 1;
        south = (r + 1 >= n) ? 0 : r + 1;
        west  = (c == 0) ? n - 1 : c - 1;
        east  = (c + 1 >= n) ? 0 : c + 1;
        return spin_of(north, c) + spin_of(south, c) + spin_of(r, west) + spin_of(r, east);
    endfunction

    function automatic int clamp_total(int v, int lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic void flip_site(int r, int c, int de);
        int old;
        old = spin_of(r, c);
        lattice_up[r * MAX_SIDE + c] = ~lattice_up[r * MAX_SIDE + c];
        energy_now = clamp_total(energy_now + de, E_LIM);
        magnet_now = clamp_total(magnet_now - 2 * old, M_LIM);
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b, logic [63:0] cap);
        return (a > cap - b) ? cap : a + b;
    endfunction

    // Apply one accepted beat to the lattice and return the result it must produce
    function automatic result_t predict_step(beat_t b);
        result_t res;
        int      n, r, c, s, de;
        bit      hit, take;
        longint  e, m, esum;
        n   = lattice_side();
        r   = b.row;
        c   = b.col;
        hit = (r < n) && (c < n);
        res = '0;
        if (b.kind == KIND_SET && hit)
        begin
            s = spin_of(r, c);
            if ((s > 0) != b.up)
                flip_site(r, c, 2 * s * neighbour_total(r, c, n));
        end
        else if (b.kind == KIND_FLIP && hit)
        begin
            de   = 2 * spin_of(r, c) * neighbour_total(r, c, n);
            take = (de <= 0)
                || (de == DE_PLUS4 && b.frac <= th4_cfg)
                || (de == DE_PLUS8 && b.frac <= th8_cfg);
            if (take)
            begin
                flip_site(r, c, de);
                res.flipped = 1'b1;
                if (sweeps_done >= warmup_cfg)
                    flips_counted = add_sat(flips_counted, 64'd1, CNT_MAX);
            end
        end
        else if (b.kind == KIND_CYCLE)
        begin
            if (sweeps_done >= warmup_cfg)
            begin
                e    = energy_now;
                m    = magnet_now;
                esum = energy_sum + e;
                if (esum > ESUM_MAX)
                    esum = ESUM_MAX;
                if (esum < ESUM_MIN)
                    esum = ESUM_MIN;
                energy_sum    = esum;
                energy_sq_sum = add_sat(energy_sq_sum, e * e, USUM_MAX);
                mag_sq_sum    = add_sat(mag_sq_sum, m * m, USUM_MAX);
                abs_mag_sum   = add_sat(abs_mag_sum, (m < 0) ? -m : m, USUM_MAX);
            end
            sweeps_done = add_sat(sweeps_done, 64'd1, CNT_MAX);
        end
        res.energy          = energy_now[E_W-1:0];
        res.magnetization   = magnet_now[M_W-1:0];
        res.sum_energy      = energy_sum[ACC_W-1:0];
        res.sum_energy_sq   = energy_sq_sum[ACC_W-1:0];
        res.sum_mag_sq      = mag_sq_sum[ACC_W-1:0];
        res.sum_abs_mag     = abs_mag_sum[ACC_W-1:0];
        res.measured_cycles = (sweeps_done > warmup_cfg) ?
                              CNT_W'(sweeps_done - warmup_cfg) : '0;
        res.accepted_count  = flips_counted[CNT_W-1:0];
        return res;
    endfunction

    function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatches = mismatches + 1;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Input driver: changes on the falling edge. A beat on offer stays put
    // until the monitor has counted its handshake; then the next one goes
    // out in the same step, so tvalid never drops between back-to-back beats.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && beats_taken == beats_seen))
        begin
            beats_seen = beats_taken;
            if (beats_to_send.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT))
            begin
                next_beat = beats_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {3'b000, next_beat.frac, next_beat.up, next_beat.col, next_beat.row};
                s_tuser  <= next_beat.kind;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result side ready: random idles, plus a long hold-off on request,
    // counted down here so the lattice engine backs up into its input.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (holds_served != holds_asked)
        begin
            holds_served = holds_served + 1;
            hold_left    = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
            m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Monitor on the rising edge: check the result beat against the oldest
    // prediction, then predict for any input beat taken at this edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                seen_res = m_tdata[$bits(result_t)-1:0];
                if (pending_results.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    $display("%0t: result beat with nothing expected, expected none, actual %0h",
                             $time, seen_res);
                end
                else
                begin
                    result_t want;
                    want = pending_results.pop_front();
                    check_field("flipped", want.flipped, seen_res.flipped);
                    check_field("energy", want.energy, seen_res.energy);
                    check_field("magnetization", want.magnetization, seen_res.magnetization);
                    check_field("sum_energy", want.sum_energy, seen_res.sum_energy);
                    check_field("sum_energy_sq", want.sum_energy_sq, seen_res.sum_energy_sq);
                    check_field("sum_mag_sq", want.sum_mag_sq, seen_res.sum_mag_sq);
                    check_field("sum_abs_mag", want.sum_abs_mag, seen_res.sum_abs_mag);
                    check_field("measured_cycles", want.measured_cycles,
                                seen_res.measured_cycles);
                    check_field("accepted_count", want.accepted_count, seen_res.accepted_count);
                end
            end
            if (s_tvalid && s_tready)
            begin
                taken_beat = {s_tuser, s_tdata[$bits(beat_t)-3:0]};
                pending_results.push_back(predict_step(taken_beat));
                beats_taken = beats_taken + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_beat(input logic [1:0] kind, input int r, input int c,
                             input bit up, input logic [PROB_BITS-1:0] frac);
        beat_t b;
        b.kind = kind;
        b.row  = IDX_W'(r);
        b.col  = IDX_W'(c);
        b.up   = up;
        b.frac = frac;
        beats_to_send.push_back(b);
    endtask

    // Wait until every beat has gone in and every result has come out, then
    // let the pipeline settle before touching registers.
    task automatic drain();
        while (beats_to_send.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write (setup + access), then read back and compare the register
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] want;
        logic [31:0] got;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SIDE:
            begin
                side_cfg = value[SIDE_W-1:0];
                want     = side_cfg;
            end
            REG_TH4:
            begin
                th4_cfg = value[PROB_BITS-1:0];
                want    = th4_cfg;
            end
            REG_TH8:
            begin
                th8_cfg = value[PROB_BITS-1:0];
                want    = th8_cfg;
            end
            default:
            begin
                warmup_cfg = value;
                want       = warmup_cfg;
            end
        endcase
        @(negedge clk);
        psel <= 1'b1;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        check_field("register readback", want, got);
    endtask

    // Mostly in-range flips with a few sets and sweep markers; noise beats
    // (out-of-range sites, kind 3) ride along but are not counted.
    task automatic random_run(input int count);
        beat_t b;
        int    n, made, pick;
        n    = lattice_side();
        made = 0;
        while (made < count)
        begin
            pick   = $urandom_range(99);
            b.kind = KIND_FLIP;
            b.row  = IDX_W'($urandom_range(n - 1));
            b.col  = IDX_W'($urandom_range(n - 1));
            b.up   = 1'($urandom_range(1));
            b.frac = PROB_BITS'($urandom);
            made   = made + 1;
            if (pick < 8)
                b.kind = KIND_SET;
            else if (pick < 78)
            begin
                // land right on or next to a threshold now and then
                if ($urandom_range(3) == 0)
                    b.frac = ($urandom_range(1) ? th4_cfg : th8_cfg)
                           + PROB_BITS'($urandom_range(2)) - PROB_BITS'(1);
            end
            else if (pick < 88)
                b.kind = KIND_CYCLE;
            else
            begin
                made = made - 1;
                if (n < MAX_SIDE && $urandom_range(1) == 1)
                begin
                    b.kind = $urandom_range(1) ? KIND_SET : KIND_FLIP;
                    if ($urandom_range(1) == 1)
                        b.row = IDX_W'($urandom_range(MAX_SIDE - 1, n));
                    else
                        b.col = IDX_W'($urandom_range(MAX_SIDE - 1, n));
                end
                else
                    b.kind = KIND_NONE;
            end
            beats_to_send.push_back(b);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int phase;
        foreach (lattice_up[i])
            lattice_up[i] = 1'b1;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings: side 16, all spins up, thresholds 1200 / 22
        push_beat(KIND_FLIP, 0, 0, 1'b0, 16'd0);        // dE +8, frac at zero: taken
        push_beat(KIND_FLIP, 0, 0, 1'b1, 16'hFFFF);     // flipping back is downhill
        push_beat(KIND_FLIP, 5, 5, 1'b0, 16'hFFFF);     // dE +8, frac too big
        push_beat(KIND_SET, 3, 3, 1'b0, 16'h0000);
        push_beat(KIND_FLIP, 3, 4, 1'b0, 16'd1200);     // dE +4 right at threshold
        push_beat(KIND_FLIP, 3, 2, 1'b0, 16'd1201);     // dE +4 one above threshold
        push_beat(KIND_SET, 3, 3, 1'b0, 16'hFFFF);      // same spin again: no change
        push_beat(KIND_SET, 16, 0, 1'b0, 16'h0000);     // row just past the side
        push_beat(KIND_SET, 0, 63, 1'b0, 16'h0000);     // col far past the side
        push_beat(KIND_FLIP, 63, 63, 1'b1, 16'h0000);
        push_beat(KIND_NONE, 63, 63, 1'b1, 16'hFFFF);
        push_beat(KIND_CYCLE, 0, 0, 1'b0, 16'h0000);
        push_beat(KIND_FLIP, 15, 15, 1'b1, 16'd22);     // dE +8 at its threshold
        push_beat(KIND_CYCLE, 63, 63, 1'b1, 16'hFFFF);
        push_beat(KIND_SET, 3, 3, 1'b1, 16'h0000);
        drain();

        // Smallest lattice: doubled neighbours, warm-up of three sweeps
        write_reg(REG_WARMUP, 32'd3);
        write_reg(REG_SIDE, 32'd2);
        write_reg(REG_TH4, 32'd0);
        write_reg(REG_TH8, 32'hFFFF);
        push_beat(KIND_SET, 1, 1, 1'b0, 16'h0000);
        push_beat(KIND_FLIP, 0, 0, 1'b0, 16'hFFFF);
        push_beat(KIND_FLIP, 0, 1, 1'b0, 16'h0000);
        push_beat(KIND_SET, 2, 0, 1'b1, 16'h0000);      // outside a side of 2
        repeat (4)
            push_beat(KIND_CYCLE, 0, 0, 1'b0, 16'h0000);
        push_beat(KIND_FLIP, 1, 0, 1'b1, 16'h0001);
        push_beat(KIND_CYCLE, 1, 1, 1'b1, 16'h0000);
        drain();

        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    // full lattice, always accept, no idling anywhere
                    write_reg(REG_SIDE, MAX_SIDE);
                    write_reg(REG_TH4, 32'hFFFF);
                    write_reg(REG_TH8, 32'hFFFF);
                    write_reg(REG_WARMUP, 32'd0);
                    no_idle = 1'b1;
                end
                1:
                begin
                    // side 0 acts as 2; warm-up never ends
                    write_reg(REG_SIDE, 32'd0);
                    write_reg(REG_TH4, 32'd0);
                    write_reg(REG_TH8, 32'd0);
                    write_reg(REG_WARMUP, 32'hFFFF_FFFF);
                    no_idle = 1'b0;
                    holds_asked = holds_asked + 1;
                end
                2:
                begin
                    // 127 acts as MAX_SIDE
                    write_reg(REG_SIDE, 32'd127);
                    write_reg(REG_TH4, $urandom_range(16'hFFFF));
                    write_reg(REG_TH8, $urandom_range(16'hFFFF));
                    write_reg(REG_WARMUP, 32'd10);
                end
                default:
                begin
                    case ($urandom_range(7))
                        0:       write_reg(REG_SIDE, 32'd1);
                        1:       write_reg(REG_SIDE, 32'd3);
                        2:       write_reg(REG_SIDE, 32'd4);
                        3:       write_reg(REG_SIDE, 32'd5);
                        4:       write_reg(REG_SIDE, 32'd8);
                        5:       write_reg(REG_SIDE, 32'd33);
                        6:       write_reg(REG_SIDE, 32'd65);
                        default: write_reg(REG_SIDE, 32'd16);
                    endcase
                    write_reg(REG_TH4, $urandom_range(16'hFFFF));
                    write_reg(REG_TH8, $urandom_range(16'hFFFF));
                    write_reg(REG_WARMUP, $urandom_range(30));
                end
            endcase
            random_run(95);
            // sender sits still mid-phase until every result is back
            if (phase == 2)
                drain();
            random_run(92);
            drain();
        end

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(CLK_PERIOD * RUN_LIMIT_CYCLES);
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
